### hdl/rlbp_pkg.sv
package rlbp_pkg;

    localparam int WORD_BITS = 32;

    typedef struct packed {
        logic [15:0] run_length;
        logic        line_start;
        logic [11:0] line_number;
    } in_item_t;

    typedef struct packed {
        logic [31:0] pixel_word;
        logic [5:0]  word_index;
        logic [12:0] target_row;
        logic        also_next_row;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [11:0] line_width;
        logic [11:0] page_height;
        logic        invert;
        logic        fine_rows;
    } cfg_t;

    typedef enum logic [1:0] {
        REG_LINE_WIDTH  = 2'd0,
        REG_PAGE_HEIGHT = 2'd1,
        REG_INVERT      = 2'd2,
        REG_FINE_ROWS   = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_EVAL  = 2'd1,
        ST_DRAW  = 2'd2,
        ST_FLUSH = 2'd3
    } state_t;

    typedef struct packed {
        logic load;
        logic first;
        logic step;
        logic emit_flush;
        logic end_line;
    } cmd_t;

    typedef struct packed {
        logic line_active;
        logic overshoot;
        logic bits_nz;
        logic word_full;
        logic rem_zero_after;
        logic end_hit;
        logic bits_nz_after;
        logic slot_free;
    } status_t;

endpackage

### hdl/rlbp_cfg.sv
module rlbp_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output rlbp_pkg::cfg_t      cfg
);

    rlbp_pkg::cfg_t cfg_reg;
    rlbp_pkg::cfg_t cfg_next;
    rlbp_pkg::reg_index_t index;
    logic wr_en;

    assign index  = rlbp_pkg::reg_index_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (index)
                rlbp_pkg::REG_LINE_WIDTH:  cfg_next.line_width  = pwdata[11:0];
                rlbp_pkg::REG_PAGE_HEIGHT: cfg_next.page_height = pwdata[11:0];
                rlbp_pkg::REG_INVERT:      cfg_next.invert      = pwdata[0];
                rlbp_pkg::REG_FINE_ROWS:   cfg_next.fine_rows   = pwdata[0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            rlbp_pkg::REG_LINE_WIDTH:  prdata = {20'd0, cfg_reg.line_width};
            rlbp_pkg::REG_PAGE_HEIGHT: prdata = {20'd0, cfg_reg.page_height};
            rlbp_pkg::REG_INVERT:      prdata = {31'd0, cfg_reg.invert};
            rlbp_pkg::REG_FINE_ROWS:   prdata = {31'd0, cfg_reg.fine_rows};
            default:                   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_width  <= 12'd1728;
            cfg_reg.page_height <= 12'd4095;
            cfg_reg.invert      <= 1'b0;
            cfg_reg.fine_rows   <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hdl/rlbp_ctrl.sv
module rlbp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  rlbp_pkg::status_t status,
    output rlbp_pkg::cmd_t    cmd
);

    rlbp_pkg::state_t state_reg;
    rlbp_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rlbp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_stall       = 1'b1;
        cmd.first      = (state_reg == rlbp_pkg::ST_EVAL);
        unique case (state_reg)
            rlbp_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = rlbp_pkg::ST_EVAL;
                end
            end
            rlbp_pkg::ST_EVAL, rlbp_pkg::ST_DRAW:
            begin
                if ((state_reg == rlbp_pkg::ST_EVAL) && !status.line_active)
                begin
                    state_next = rlbp_pkg::ST_IDLE;
                end
                else if ((state_reg == rlbp_pkg::ST_EVAL) && status.overshoot)
                begin
                    // An overshooting run is not drawn; it only closes the line.
                    if (status.bits_nz)
                    begin
                        state_next = rlbp_pkg::ST_FLUSH;
                    end
                    else
                    begin
                        cmd.end_line = 1'b1;
                        state_next   = rlbp_pkg::ST_IDLE;
                    end
                end
                else if (!(status.word_full && !status.slot_free))
                begin
                    cmd.step = 1'b1;
                    if (status.rem_zero_after)
                    begin
                        state_next = rlbp_pkg::ST_IDLE;
                        if (status.end_hit)
                        begin
                            if (status.bits_nz_after)
                            begin
                                state_next = rlbp_pkg::ST_FLUSH;
                            end
                            else
                            begin
                                cmd.end_line = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        state_next = rlbp_pkg::ST_DRAW;
                    end
                end
            end
            rlbp_pkg::ST_FLUSH:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_flush = 1'b1;
                    cmd.end_line   = 1'b1;
                    state_next     = rlbp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rlbp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/rlbp_dp.sv
module rlbp_dp #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_LINES = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rlbp_pkg::in_item_t  in_data,
    input  rlbp_pkg::cfg_t      cfg,
    input  rlbp_pkg::cmd_t      cmd,
    output rlbp_pkg::status_t   status,
    input  logic                out_stall,
    output logic                out_valid,
    output rlbp_pkg::out_item_t out_data
);

    localparam int PW = $clog2(MAX_WIDTH + 1);
    localparam logic [11:0] MAX_W12 = 12'(MAX_WIDTH);
    localparam logic [12:0] MAX_L13 = 13'(MAX_LINES);
    localparam logic [5:0]  WORD6   = 6'(rlbp_pkg::WORD_BITS);

    logic [15:0]   run_reg,    run_next;
    logic [31:0]   acc_reg,    acc_next;
    logic [4:0]    bits_reg,   bits_next;
    logic          colour_reg, colour_next;
    logic [PW-1:0] pix_reg,    pix_next;
    logic [5:0]    words_reg,  words_next;
    logic          active_reg, active_next;
    logic [11:0]   line_reg,   line_next;
    logic [PW-1:0] rem_reg,    rem_next;
    logic          end_reg,    end_next;
    logic          out_valid_reg, out_valid_next;
    rlbp_pkg::out_item_t out_data_reg, out_data_next;

    logic [11:0]   width12;
    logic [16:0]   width17;
    logic [16:0]   sum;
    logic [PW-1:0] src_rem;
    logic [5:0]    space;
    logic [5:0]    take;
    logic [PW-1:0] rem_after;
    logic [5:0]    bits_sum;
    logic [31:0]   mask;
    logic [31:0]   acc_drawn;
    logic          slot_free;
    logic          emit;
    logic          end_hit;

    always_comb
    begin
        if (cfg.line_width == 12'd0)
        begin
            width12 = 12'd1;
        end
        else if (cfg.line_width > MAX_W12)
        begin
            width12 = MAX_W12;
        end
        else
        begin
            width12 = cfg.line_width;
        end
    end

    assign width17 = {5'd0, width12};
    assign sum     = 17'(pix_reg) + {1'b0, run_reg};

    // Where the run fits, it is no longer than the width, so it fits the counter.
    assign src_rem   = cmd.first ? run_reg[PW-1:0] : rem_reg;
    assign space     = WORD6 - {1'b0, bits_reg};
    assign take      = (src_rem < PW'(space)) ? src_rem[5:0] : space;
    assign rem_after = src_rem - PW'(take);
    assign bits_sum  = {1'b0, bits_reg} + take;
    assign end_hit   = cmd.first ? (sum == width17) : end_reg;

    assign mask = (32'hFFFF_FFFF >> bits_reg)
                & ~(bits_sum[5] ? 32'h0 : (32'hFFFF_FFFF >> bits_sum[4:0]));
    assign acc_drawn = colour_reg ? (acc_reg | mask) : acc_reg;

    assign slot_free = !out_valid_reg || !out_stall;
    assign emit      = (cmd.step && bits_sum[5]) || cmd.emit_flush;

    always_comb
    begin
        status.line_active    = active_reg;
        status.overshoot      = (sum > width17);
        status.bits_nz        = (bits_reg != 5'd0);
        status.word_full      = bits_sum[5];
        status.rem_zero_after = (rem_after == '0);
        status.end_hit        = end_hit;
        status.bits_nz_after  = (bits_sum[4:0] != 5'd0);
        status.slot_free      = slot_free;
    end

    always_comb
    begin
        run_next    = run_reg;
        acc_next    = acc_reg;
        bits_next   = bits_reg;
        colour_next = colour_reg;
        pix_next    = pix_reg;
        words_next  = words_reg;
        active_next = active_reg;
        line_next   = line_reg;
        rem_next    = rem_reg;
        end_next    = end_reg;

        if (cmd.load)
        begin
            run_next = in_data.run_length;
            if (in_data.line_start)
            begin
                acc_next    = 32'd0;
                bits_next   = 5'd0;
                pix_next    = '0;
                words_next  = 6'd0;
                colour_next = cfg.invert;
                line_next   = in_data.line_number;
                active_next = (in_data.line_number < cfg.page_height)
                           && ({1'b0, in_data.line_number} < MAX_L13);
            end
        end

        if (cmd.step)
        begin
            acc_next  = bits_sum[5] ? 32'd0 : acc_drawn;
            bits_next = bits_sum[4:0];
            rem_next  = rem_after;
            if (cmd.first)
            begin
                pix_next = sum[PW-1:0];
                end_next = (sum == width17);
            end
            if (rem_after == '0)
            begin
                colour_next = ~colour_reg;
            end
        end

        if (emit)
        begin
            words_next = words_reg + 6'd1;
        end

        if (cmd.end_line)
        begin
            acc_next    = 32'd0;
            bits_next   = 5'd0;
            active_next = 1'b0;
        end
    end

    // A full word is the last of its request when the pixels still to come
    // fill no further word and leave nothing to flush at the line end.
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            out_valid_next               = 1'b1;
            out_data_next.pixel_word     = cmd.emit_flush ? acc_reg : acc_drawn;
            out_data_next.word_index     = words_reg;
            out_data_next.target_row     = cfg.fine_rows ? {1'b0, line_reg} : {line_reg, 1'b0};
            out_data_next.also_next_row  = ~cfg.fine_rows;
            out_data_next.last           = cmd.emit_flush
                                        || ((rem_after < PW'(WORD6))
                                            && (!end_hit || (rem_after == '0)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 16'd0;
            acc_reg       <= 32'd0;
            bits_reg      <= 5'd0;
            colour_reg    <= 1'b0;
            pix_reg       <= '0;
            words_reg     <= 6'd0;
            active_reg    <= 1'b0;
            line_reg      <= 12'd0;
            rem_reg       <= '0;
            end_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            run_reg       <= run_next;
            acc_reg       <= acc_next;
            bits_reg      <= bits_next;
            colour_reg    <= colour_next;
            pix_reg       <= pix_next;
            words_reg     <= words_next;
            active_reg    <= active_next;
            line_reg      <= line_next;
            rem_reg       <= rem_next;
            end_reg       <= end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### hdl/run_length_to_bitmap_packer_unit.sv
// Run-length to bitmap packer for bilevel fax lines.
// The input channel (in_valid, in_stall, in_data) carries one request per pixel run;
// runs alternate in colour, and a request with line_start set opens a new line
// numbered line_number. The output channel (out_valid, out_stall, out_data) carries
// 32-pixel words, first pixel in the most significant bit, tagged with their word
// index, image row and a flag on the last word caused by each request.
// Line width, page height, colour inversion and row doubling are set over the
// APB port, registers at byte addresses 0, 4, 8 and 12; the user must set them only
// while the block is idle, which the block itself does not enforce. A request is
// taken in one cycle and evaluated in the next; the packer then places up to one
// word's worth of pixels per cycle unless a full word waits for the output slot.
// A new request is taken only once the packer is idle again. A word filled in the
// first packing step is registered at the output at the end of the evaluation state.
// A word is held in an output register while the receiver stalls; the next request
// is still accepted, and packing only waits when another word is ready to leave.
// Reset clears the line state, leaves no line open and restores the default
// registers: width 1728, height 4095, no inversion, fine rows.
module run_length_to_bitmap_packer_unit #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_LINES = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  rlbp_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output rlbp_pkg::out_item_t out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    rlbp_pkg::cfg_t    cfg;
    rlbp_pkg::cmd_t    cmd;
    rlbp_pkg::status_t status;

    rlbp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rlbp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    rlbp_dp #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_LINES (MAX_LINES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg       (cfg),
        .cmd       (cmd),
        .status    (status),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

### hdl/rlbp_checker.sv
module rlbp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input rlbp_pkg::out_item_t out_data
);

    // A request is always evaluated in the cycle after it is taken.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted twice in consecutive cycles");

    // Doubled rows always start on an even row.
    a_even_double_row: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.also_next_row) |-> !out_data.target_row[0])
        else $error("doubled word targets an odd row");

    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("output dropped while stalled");

    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(out_data))
        else $error("output changed while stalled");

endmodule

bind run_length_to_bitmap_packer_unit rlbp_checker u_rlbp_checker (.*);

### bench/rlbp_checker.sv
`timescale 1ns / 1ps

module rlbp_scoreboard (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  rlbp_pkg::in_item_t  in_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  rlbp_pkg::out_item_t out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    input  logic                wrap_up,
    output int                  outstanding,
    output int                  mismatches,
    output int                  words_seen
);

    localparam int MAX_WIDTH = 2048;
    localparam int MAX_LINES = 4096;

    rlbp_pkg::cfg_t      regs;
    logic [31:0]         acc;
    int                  fill;
    logic                colour;
    int                  px_done;
    logic [5:0]          word_cnt;
    logic                line_open;
    logic [11:0]         line_no;
    rlbp_pkg::out_item_t expected_words[$];
    rlbp_pkg::out_item_t held_word;
    logic                held_valid;
    rlbp_pkg::out_item_t want;
    logic                wrapped;

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    // The previous word is queued once a newer one exists, or at the end of the request,
    // so that the final word of a request can still be marked as last.
    task automatic emit_word();
        if (held_valid)
        begin
            expected_words.push_back(held_word);
        end
        held_word.pixel_word    = acc;
        held_word.word_index    = word_cnt;
        held_word.target_row    = regs.fine_rows ? {1'b0, line_no} : {line_no, 1'b0};
        held_word.also_next_row = ~regs.fine_rows;
        held_word.last          = 1'b0;
        held_valid = 1'b1;
        word_cnt   = word_cnt + 6'd1;
    endtask

    task automatic close_line();
        if (fill != 0)
        begin
            emit_word();
        end
        acc       = '0;
        fill      = 0;
        line_open = 1'b0;
    endtask

    task automatic pack_run(input rlbp_pkg::in_item_t req);
        int w;
        int p;
        held_valid = 1'b0;
        w = int'(regs.line_width);
        if (w == 0)
        begin
            w = 1;
        end
        if (w > MAX_WIDTH)
        begin
            w = MAX_WIDTH;
        end
        if (req.line_start)
        begin
            acc       = '0;
            fill      = 0;
            px_done   = 0;
            word_cnt  = '0;
            colour    = regs.invert;
            line_no   = req.line_number;
            line_open = (req.line_number < regs.page_height)
                        && (int'(req.line_number) < MAX_LINES);
        end
        if (line_open)
        begin
            if (px_done + int'(req.run_length) > w)
            begin
                // A run that would pass the line end is dropped and closes the line.
                close_line();
            end
            else
            begin
                for (p = 0; p < int'(req.run_length); p++)
                begin
                    acc[31 - fill] = colour;
                    fill++;
                    if (fill == rlbp_pkg::WORD_BITS)
                    begin
                        emit_word();
                        acc  = '0;
                        fill = 0;
                    end
                end
                px_done += int'(req.run_length);
                colour = ~colour;
                if (px_done == w)
                begin
                    close_line();
                end
            end
        end
        if (held_valid)
        begin
            held_word.last = 1'b1;
            expected_words.push_back(held_word);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.line_width  = 12'd1728;
            regs.page_height = 12'd4095;
            regs.invert      = 1'b0;
            regs.fine_rows   = 1'b1;
            acc        = '0;
            fill       = 0;
            colour     = 1'b0;
            px_done    = 0;
            word_cnt   = '0;
            line_open  = 1'b0;
            line_no    = '0;
            held_valid = 1'b0;
            wrapped    = 1'b0;
            mismatches = 0;
            words_seen = 0;
            expected_words.delete();
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (rlbp_pkg::reg_index_t'(paddr[3:2]))
                    rlbp_pkg::REG_LINE_WIDTH:  regs.line_width  = pwdata[11:0];
                    rlbp_pkg::REG_PAGE_HEIGHT: regs.page_height = pwdata[11:0];
                    rlbp_pkg::REG_INVERT:      regs.invert      = pwdata[0];
                    rlbp_pkg::REG_FINE_ROWS:   regs.fine_rows   = pwdata[0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    flag_mismatch($sformatf("word %08h arrived with nothing expected",
                                            out_data.pixel_word));
                end
                else
                begin
                    want = expected_words.pop_front();
                    words_seen++;
                    if (out_data.pixel_word !== want.pixel_word)
                        flag_mismatch($sformatf("pixel_word %08h, expected %08h",
                                                out_data.pixel_word, want.pixel_word));
                    if (out_data.word_index !== want.word_index)
                        flag_mismatch($sformatf("word_index %0d, expected %0d",
                                                out_data.word_index, want.word_index));
                    if (out_data.target_row !== want.target_row)
                        flag_mismatch($sformatf("target_row %0d, expected %0d",
                                                out_data.target_row, want.target_row));
                    if (out_data.also_next_row !== want.also_next_row)
                        flag_mismatch($sformatf("also_next_row %b, expected %b",
                                                out_data.also_next_row, want.also_next_row));
                    if (out_data.last !== want.last)
                        flag_mismatch($sformatf("last %b, expected %b",
                                                out_data.last, want.last));
                end
            end
            if (in_valid && !in_stall)
            begin
                pack_run(in_data);
            end
            if (wrap_up && !wrapped)
            begin
                wrapped = 1'b1;
                if (expected_words.size() != 0)
                    flag_mismatch($sformatf("%0d expected words never delivered",
                                            expected_words.size()));
            end
            outstanding <= expected_words.size();
        end
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_WIDTH   = 2048;
    localparam int RANDOM_RUNS = 430;
    localparam int CALM_FROM   = 370;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 300;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    rlbp_pkg::in_item_t  in_data   = '0;
    logic                out_stall = 1'b0;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [3:0]          paddr     = '0;
    logic [31:0]         pwdata    = '0;
    logic                wrap_up   = 1'b0;

    logic                in_stall;
    logic                out_valid;
    rlbp_pkg::out_item_t out_data;
    logic [31:0]         prdata;
    logic                pready;

    int                  outstanding;
    int                  mismatches;
    int                  words_seen;
    int                  total_runs   = 0;
    int                  random_runs  = 0;
    int                  settings     = 0;
    logic                random_phase = 1'b0;
    logic                calm         = 1'b0;
    logic                held         = 1'b0;
    rlbp_pkg::cfg_t      shadow;

    always #4 clk = ~clk;

    run_length_to_bitmap_packer_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    rlbp_scoreboard u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .wrap_up    (wrap_up),
        .outstanding(outstanding),
        .mismatches (mismatches),
        .words_seen (words_seen)
    );

    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic write_reg(input rlbp_pkg::reg_index_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Lets the packer drain fully, including requests that produce no words.
    task automatic settle();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apply_setting(input int width, input int height,
                                 input logic inv, input logic fine);
        settle();
        write_reg(rlbp_pkg::REG_LINE_WIDTH, width);
        write_reg(rlbp_pkg::REG_PAGE_HEIGHT, height);
        write_reg(rlbp_pkg::REG_INVERT, {31'd0, inv});
        write_reg(rlbp_pkg::REG_FINE_ROWS, {31'd0, fine});
        shadow.line_width  = width[11:0];
        shadow.page_height = height[11:0];
        shadow.invert      = inv;
        shadow.fine_rows   = fine;
        settings++;
    endtask

    task automatic send_run(input int len, input logic start, input logic [11:0] num);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data.run_length  <= len[15:0];
        in_data.line_start  <= start;
        in_data.line_number <= num;
        do @(posedge clk); while (in_stall);
        total_runs++;
        if (random_phase)
            random_runs++;
        if (random_runs >= CALM_FROM)
            calm = 1'b1;
    endtask

    // One line of runs that mostly fills the width exactly; some lines end
    // with an overshooting run and some are abandoned for the next line.
    task automatic play_line();
        int w;
        int rem;
        int len;
        int plan;
        logic [11:0] num;
        logic first;
        w = int'(shadow.line_width);
        if (w == 0)
            w = 1;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        rem   = w;
        first = 1'b1;
        if (shadow.page_height != 0 && $urandom_range(0, 7) != 0)
            num = 12'($urandom_range(0, int'(shadow.page_height) - 1));
        else
            num = 12'($urandom_range(0, 4095));
        plan = $urandom_range(0, 7);
        forever
        begin
            if (plan == 0 && $urandom_range(0, 3) == 0)
            begin
                send_run($urandom_range(rem + 1, 65535), first, num);
                break;
            end
            if (plan == 1 && !first && $urandom_range(0, 4) == 0)
                break;
            if ($urandom_range(0, 5) == 0)
                len = $urandom_range(0, rem);
            else
                len = $urandom_range(0, rem < 40 ? rem : 40);
            send_run(len, first, num);
            first = 1'b0;
            rem -= len;
            if (rem == 0)
                break;
        end
    endtask

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (!held && random_runs >= HOLD_AT)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                held = 1'b1;
            end
            else if (!calm && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    initial
    begin
        int phase_left;
        int guard;
        shadow.line_width  = 12'd1728;
        shadow.page_height = 12'd4095;
        shadow.invert      = 1'b0;
        shadow.fine_rows   = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A whole line at the reset settings.
        send_run(1728, 1'b1, 12'd0);

        apply_setting(40, 10, 1'b0, 1'b1);
        send_run(5, 1'b0, 12'd0);          // run with no open line
        send_run(0, 1'b1, 12'd0);          // zero-length run still swaps colour
        send_run(3, 1'b0, 12'd0);
        send_run(37, 1'b0, 12'd0);
        send_run(65535, 1'b1, 12'd9);      // overshoot with nothing drawn
        send_run(4, 1'b0, 12'd0);
        send_run(5, 1'b1, 12'd10);         // line at the page height is dropped
        send_run(5, 1'b0, 12'd0);
        send_run(1, 1'b1, 12'd4095);
        send_run(10, 1'b1, 12'd3);
        send_run(20, 1'b0, 12'd0);
        send_run(40, 1'b1, 12'd4);         // new line discards the unfinished one
        send_run(33, 1'b1, 12'd5);
        send_run(10, 1'b0, 12'd0);         // overshoot flushes a partial word

        apply_setting(0, 4095, 1'b1, 1'b0);
        send_run(1, 1'b1, 12'd4094);
        send_run(1, 1'b1, 12'd4095);

        apply_setting(4095, 4095, 1'b0, 1'b0);
        send_run(2048, 1'b1, 12'd7);

        apply_setting(2048, 0, 1'b1, 1'b1);
        send_run(10, 1'b1, 12'd0);

        // The width changes while a line is still open.
        apply_setting(100, 4095, 1'b0, 1'b1);
        send_run(60, 1'b1, 12'd8);
        apply_setting(80, 4095, 1'b1, 1'b0);
        send_run(20, 1'b0, 12'd0);

        random_phase = 1'b1;
        phase_left = 0;
        while (random_runs < RANDOM_RUNS)
        begin
            if (phase_left <= 0)
            begin
                int w;
                int h;
                case ($urandom_range(0, 9))
                    0:       w = MAX_WIDTH;
                    1:       w = $urandom_range(MAX_WIDTH + 1, 4095);
                    2:       w = $urandom_range(0, 1);
                    default: w = $urandom_range(2, 200);
                endcase
                h = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4095) : 4095;
                apply_setting(w, h, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                phase_left = $urandom_range(30, 80);
            end
            if ($urandom_range(0, 9) == 0)
            begin
                send_run(int'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                         12'($urandom_range(0, 4095)));
                phase_left--;
            end
            else
            begin
                phase_left += random_runs;
                play_line();
                phase_left -= random_runs;
            end
        end

        in_valid <= 1'b0;
        calm = 1'b1;
        repeat (2) @(posedge clk);
        guard = 0;
        while (outstanding != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
        wrap_up <= 1'b1;
        repeat (2) @(posedge clk);

        $display("run covered %0d run requests (%0d random) over %0d register settings",
                 total_runs, random_runs, settings);
        $display("%0d packed words compared against the predicted line bitmaps", words_seen);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
